@@ hdl/cpc_pkg.sv @@
// Shared types and constants for the channel preference checker.
`timescale 1ns / 1ps

package cpc_pkg;

   localparam int MAX_GROUPS_DEF   = 8;
   localparam int NUM_CHANNELS_DEF = 13;

   localparam logic [7:0]  KIND_PREFERENCE  = 8'h8B;
   localparam logic [7:0]  KIND_POWER       = 8'h8D;
   localparam logic [15:0] TLV_ID_AND_COUNT = 16'd7;   // radio id plus one more byte
   localparam logic [2:0]  ID_BYTES         = 3'd6;
   localparam logic [3:0]  SCORE_RESERVED   = 4'd15;
   localparam logic [3:0]  REASON_MAX       = 4'd13;
   localparam logic [3:0]  REASON_RSVD_LO   = 4'd6;
   localparam logic [3:0]  REASON_RSVD_HI   = 4'd10;
   localparam logic [7:0]  ADV_CLASS_RST    = 8'd81;
   localparam logic [3:0]  OPERABLE_RST     = 4'd6;

   typedef enum logic [1:0] {
      CMD_HEADER = 2'd0,
      CMD_VALUE  = 2'd1,
      CMD_END    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_INVALID     = 2'd1,
      STATUS_UNSUPPORTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_PREF  = 2'd1,
      ACT_POWER = 2'd2
   } active_type;

   typedef enum logic [1:0] {
      PHASE_CLASS    = 2'd0,
      PHASE_COUNT    = 2'd1,
      PHASE_CHANNELS = 2'd2,
      PHASE_SCORE    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CSR_RADIO_ID  = 2'd0,
      CSR_TX_POWER  = 2'd1,
      CSR_ADV_CLASS = 2'd2,
      CSR_OPERABLE  = 2'd3
   } csr_addr_type;

endpackage

@@ hdl/cpc_if.sv @@
// Valid/ready channel interfaces for the channel preference checker.
`timescale 1ns / 1ps

interface cpc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  tlv_kind;
   logic [15:0] tlv_length;
   logic [7:0]  data_byte;

   modport source (output valid, command, tlv_kind, tlv_length, data_byte, input ready);
   modport sink   (input valid, command, tlv_kind, tlv_length, data_byte, output ready);
endinterface

interface cpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       declined;

   modport source (output valid, status, declined, input ready);
   modport sink   (input valid, status, declined, output ready);
endinterface

interface cpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/channel_preference_checker_core.sv @@
// Top level: TLV stream checker for channel preference and transmit power TLVs.
// Throughput: one transaction per cycle on req, sustained, while rsp keeps up.
// A req transaction lands in the input register; as it retires from there its state
//   update is registered and, for an end marker, rsp valid is set by that same update.
// Only an end marker can wait in the input register, and only while rsp is full.
// Reset (synchronous, active high) clears all message state and sets the
//   configuration registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module channel_preference_checker_core #(
   parameter int MAX_GROUPS   = cpc_pkg::MAX_GROUPS_DEF,
   parameter int NUM_CHANNELS = cpc_pkg::NUM_CHANNELS_DEF
) (
   input logic      clock,
   input logic      reset,
   cpc_req_if.sink  req,
   cpc_rsp_if.source rsp,
   cpc_csr_if.sink  csr
);

   // ---------------------------------------------------------------
   // Configuration registers (the user must write them only while idle; not enforced here)
   // ---------------------------------------------------------------
   logic [47:0]       radio_id_ff;
   logic signed [7:0] tx_power_ff;
   logic [7:0]        adv_class_ff;
   logic [3:0]        operable_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radio_id_ff  <= '0;
         tx_power_ff  <= '0;
         adv_class_ff <= cpc_pkg::ADV_CLASS_RST;
         operable_ff  <= cpc_pkg::OPERABLE_RST;
      end else if (csr.valid) begin
         unique case (cpc_pkg::csr_addr_type'(csr.index))
            cpc_pkg::CSR_RADIO_ID:  radio_id_ff  <= csr.data;
            cpc_pkg::CSR_TX_POWER:  tx_power_ff  <= csr.data[7:0];
            cpc_pkg::CSR_ADV_CLASS: adv_class_ff <= csr.data[7:0];
            cpc_pkg::CSR_OPERABLE:  operable_ff  <= csr.data[3:0];
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   logic                 in_valid_ff;
   cpc_pkg::cmd_type     in_cmd_ff;
   logic [7:0]           in_kind_ff;
   logic [15:0]          in_len_ff;
   logic [7:0]           in_byte_ff;
   logic                 advance;
   logic                 rsp_valid_ff;

   // The staged item retires unless it is an end marker facing a full rsp register.
   assign advance   = in_valid_ff &&
                      (in_cmd_ff != cpc_pkg::CMD_END || !rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_cmd_ff  <= cpc_pkg::cmd_type'(req.command);
         in_kind_ff <= req.tlv_kind;
         in_len_ff  <= req.tlv_length;
         in_byte_ff <= req.data_byte;
      end
   end

   // ---------------------------------------------------------------
   // Message state
   // ---------------------------------------------------------------
   logic                    pref_seen_ff,  pref_seen_in;
   logic                    power_seen_ff, power_seen_in;
   cpc_pkg::status_type     err_ff,        err_in;
   logic                    decline_ff,    decline_in;
   cpc_pkg::active_type     active_ff,     active_in;
   logic [15:0]             bytes_left_ff, bytes_left_in;
   logic [2:0]              hdr_pos_ff,    hdr_pos_in;
   logic [3:0]              groups_left_ff, groups_left_in;
   cpc_pkg::phase_type      phase_ff,      phase_in;
   logic                    class_match_ff, class_match_in;
   logic [3:0]              chan_left_ff,  chan_left_in;
   logic [3:0]              chan_count_ff, chan_count_in;
   logic [NUM_CHANNELS-1:0] group_mask_ff, group_mask_in;
   logic [NUM_CHANNELS-1:0] claimed_ff,    claimed_in;

   // Result register
   logic                    rsp_valid_in;
   cpc_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic                    rsp_decl_ff,   rsp_decl_in;

   // One-hot channel decodes; zero when out of range.
   logic [NUM_CHANNELS-1:0] byte_bit;
   logic [NUM_CHANNELS-1:0] operable_bit;

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         byte_bit[i]     = (in_byte_ff == 8'(i + 1));
         operable_bit[i] = (operable_ff == 4'(i + 1));
      end
   end

   // Expected radio id byte, most significant first.
   logic [7:0] id_byte;

   always_comb begin
      unique case (hdr_pos_ff)
         3'd0:    id_byte = radio_id_ff[47:40];
         3'd1:    id_byte = radio_id_ff[39:32];
         3'd2:    id_byte = radio_id_ff[31:24];
         3'd3:    id_byte = radio_id_ff[23:16];
         3'd4:    id_byte = radio_id_ff[15:8];
         3'd5:    id_byte = radio_id_ff[7:0];
         default: id_byte = '0;
      endcase
   end

   // Open TLV is incomplete at a header or end marker.
   logic finish_fail;
   assign finish_fail = (err_ff == cpc_pkg::STATUS_OK) && (active_ff != cpc_pkg::ACT_NONE) &&
                        ((bytes_left_ff != '0) ||
                         (active_ff == cpc_pkg::ACT_PREF && groups_left_ff != '0));

   // Score/reason byte fields
   logic [3:0]              score;
   logic [3:0]              reason;
   logic                    code_bad;
   logic [NUM_CHANNELS-1:0] applies;

   assign score    = in_byte_ff[7:4];
   assign reason   = in_byte_ff[3:0];
   assign code_bad = (score == cpc_pkg::SCORE_RESERVED) || (reason > cpc_pkg::REASON_MAX) ||
                     (reason >= cpc_pkg::REASON_RSVD_LO && reason <= cpc_pkg::REASON_RSVD_HI);
   // A group with no channels covers every channel.
   assign applies  = (chan_count_ff != '0) ? group_mask_ff : '1;

   always_comb begin
      pref_seen_in   = pref_seen_ff;
      power_seen_in  = power_seen_ff;
      err_in         = err_ff;
      decline_in     = decline_ff;
      active_in      = active_ff;
      bytes_left_in  = bytes_left_ff;
      hdr_pos_in     = hdr_pos_ff;
      groups_left_in = groups_left_ff;
      phase_in       = phase_ff;
      class_match_in = class_match_ff;
      chan_left_in   = chan_left_ff;
      chan_count_in  = chan_count_ff;
      group_mask_in  = group_mask_ff;
      claimed_in     = claimed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_decl_in    = rsp_decl_ff;

      if (advance) begin
         unique case (in_cmd_ff)
            cpc_pkg::CMD_HEADER: begin
               if (finish_fail) begin
                  err_in = cpc_pkg::STATUS_INVALID;
               end
               active_in     = cpc_pkg::ACT_NONE;
               bytes_left_in = '0;
               if (err_in == cpc_pkg::STATUS_OK) begin
                  hdr_pos_in    = '0;
                  bytes_left_in = in_len_ff;
                  if (in_kind_ff == cpc_pkg::KIND_PREFERENCE) begin
                     if (pref_seen_ff || in_len_ff < cpc_pkg::TLV_ID_AND_COUNT) begin
                        err_in = cpc_pkg::STATUS_INVALID;
                     end else begin
                        pref_seen_in   = 1'b1;
                        active_in      = cpc_pkg::ACT_PREF;
                        groups_left_in = '0;
                        phase_in       = cpc_pkg::PHASE_CLASS;
                     end
                  end else if (in_kind_ff == cpc_pkg::KIND_POWER) begin
                     if (power_seen_ff || in_len_ff != cpc_pkg::TLV_ID_AND_COUNT) begin
                        err_in = cpc_pkg::STATUS_INVALID;
                     end else begin
                        power_seen_in = 1'b1;
                        active_in     = cpc_pkg::ACT_POWER;
                     end
                  end else begin
                     err_in = cpc_pkg::STATUS_UNSUPPORTED;
                  end
               end
            end

            cpc_pkg::CMD_VALUE: begin
               if (err_ff == cpc_pkg::STATUS_OK) begin
                  if (active_ff == cpc_pkg::ACT_NONE || bytes_left_ff == '0) begin
                     err_in = cpc_pkg::STATUS_INVALID;       // stray byte
                  end else begin
                     bytes_left_in = bytes_left_ff - 16'd1;
                     if (hdr_pos_ff < cpc_pkg::ID_BYTES) begin
                        if (id_byte != in_byte_ff) begin
                           err_in = cpc_pkg::STATUS_INVALID;
                        end else begin
                           hdr_pos_in = hdr_pos_ff + 3'd1;
                        end
                     end else if (hdr_pos_ff == cpc_pkg::ID_BYTES) begin
                        hdr_pos_in = cpc_pkg::ID_BYTES + 3'd1;
                        if (active_ff == cpc_pkg::ACT_POWER) begin
                           if ($signed(in_byte_ff) < tx_power_ff) begin
                              decline_in = 1'b1;
                           end
                        end else if (in_byte_ff > 8'(MAX_GROUPS)) begin
                           err_in = cpc_pkg::STATUS_INVALID;
                        end else begin
                           groups_left_in = in_byte_ff[3:0];
                           phase_in       = cpc_pkg::PHASE_CLASS;
                        end
                     end else if (active_ff == cpc_pkg::ACT_PREF) begin
                        if (groups_left_ff == '0) begin
                           err_in = cpc_pkg::STATUS_INVALID;  // trailing byte
                        end else begin
                           unique case (phase_ff)
                              cpc_pkg::PHASE_CLASS: begin
                                 class_match_in = (in_byte_ff == adv_class_ff);
                                 phase_in       = cpc_pkg::PHASE_COUNT;
                              end
                              cpc_pkg::PHASE_COUNT: begin
                                 if (in_byte_ff > 8'(NUM_CHANNELS)) begin
                                    err_in = cpc_pkg::STATUS_INVALID;
                                 end else begin
                                    chan_left_in  = in_byte_ff[3:0];
                                    chan_count_in = in_byte_ff[3:0];
                                    group_mask_in = '0;
                                    phase_in      = (in_byte_ff != '0) ?
                                                    cpc_pkg::PHASE_CHANNELS :
                                                    cpc_pkg::PHASE_SCORE;
                                 end
                              end
                              cpc_pkg::PHASE_CHANNELS: begin
                                 if (class_match_ff &&
                                     (byte_bit == '0 || (group_mask_ff & byte_bit) != '0)) begin
                                    err_in = cpc_pkg::STATUS_INVALID;
                                 end else begin
                                    if (class_match_ff) begin
                                       group_mask_in = group_mask_ff | byte_bit;
                                    end
                                    chan_left_in = chan_left_ff - 4'd1;
                                    if (chan_left_ff == 4'd1) begin
                                       phase_in = cpc_pkg::PHASE_SCORE;
                                    end
                                 end
                              end
                              cpc_pkg::PHASE_SCORE: begin
                                 if (code_bad ||
                                     (class_match_ff && (applies & claimed_ff) != '0)) begin
                                    err_in = cpc_pkg::STATUS_INVALID;
                                 end else begin
                                    if (class_match_ff) begin
                                       claimed_in = claimed_ff | applies;
                                       if (score == '0 && (applies & operable_bit) != '0) begin
                                          decline_in = 1'b1;
                                       end
                                    end
                                    groups_left_in = groups_left_ff - 4'd1;
                                    phase_in       = cpc_pkg::PHASE_CLASS;
                                 end
                              end
                           endcase
                        end
                     end else begin
                        err_in = cpc_pkg::STATUS_INVALID;     // power TLV too long
                     end
                  end
               end
            end

            cpc_pkg::CMD_END: begin
               rsp_status_in  = finish_fail ? cpc_pkg::STATUS_INVALID : err_ff;
               rsp_decl_in    = !finish_fail && (err_ff == cpc_pkg::STATUS_OK) && decline_ff;
               pref_seen_in   = 1'b0;
               power_seen_in  = 1'b0;
               err_in         = cpc_pkg::STATUS_OK;
               decline_in     = 1'b0;
               active_in      = cpc_pkg::ACT_NONE;
               bytes_left_in  = '0;
               hdr_pos_in     = '0;
               groups_left_in = '0;
               phase_in       = cpc_pkg::PHASE_CLASS;
               class_match_in = 1'b0;
               chan_left_in   = '0;
               chan_count_in  = '0;
               group_mask_in  = '0;
               claimed_in     = '0;
            end

            default: begin
               // unused command code: dropped
            end
         endcase
      end
   end

   // Result valid: set by a retiring end marker, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (advance && in_cmd_ff == cpc_pkg::CMD_END) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pref_seen_ff   <= 1'b0;
         power_seen_ff  <= 1'b0;
         err_ff         <= cpc_pkg::STATUS_OK;
         decline_ff     <= 1'b0;
         active_ff      <= cpc_pkg::ACT_NONE;
         bytes_left_ff  <= '0;
         hdr_pos_ff     <= '0;
         groups_left_ff <= '0;
         phase_ff       <= cpc_pkg::PHASE_CLASS;
         class_match_ff <= 1'b0;
         chan_left_ff   <= '0;
         chan_count_ff  <= '0;
         group_mask_ff  <= '0;
         claimed_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pref_seen_ff   <= pref_seen_in;
         power_seen_ff  <= power_seen_in;
         err_ff         <= err_in;
         decline_ff     <= decline_in;
         active_ff      <= active_in;
         bytes_left_ff  <= bytes_left_in;
         hdr_pos_ff     <= hdr_pos_in;
         groups_left_ff <= groups_left_in;
         phase_ff       <= phase_in;
         class_match_ff <= class_match_in;
         chan_left_ff   <= chan_left_in;
         chan_count_ff  <= chan_count_in;
         group_mask_ff  <= group_mask_in;
         claimed_ff     <= claimed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_decl_ff   <= rsp_decl_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.declined = rsp_decl_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_decline_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_decl_ff |-> rsp_status_ff == cpc_pkg::STATUS_OK)
      else $error("declined reported with nonzero status");

   a_stall_only_end: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> in_cmd_ff == cpc_pkg::CMD_END && rsp_valid_ff)
      else $error("input stage stalled without a pending result");

   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && in_cmd_ff == cpc_pkg::CMD_END |=> rsp_valid_ff)
      else $error("end marker retired without a result");

   a_no_open_bytes: assert property (@(posedge clock) disable iff (reset)
      err_ff == cpc_pkg::STATUS_OK && active_ff == cpc_pkg::ACT_NONE |-> bytes_left_ff == '0)
      else $error("bytes pending with no open transaction TLV");

   a_groups_bounded: assert property (@(posedge clock) disable iff (reset)
      err_ff == cpc_pkg::STATUS_OK |-> groups_left_ff <= 4'(MAX_GROUPS))
      else $error("group count exceeds limit");

endmodule
